@@ hdl/krt_pkg.sv @@
package krt_pkg;

  localparam int SlotsDef   = 8;
  localparam int MaxResults = 8;
  localparam int KeyW       = 32;
  localparam int ValW       = 8;
  localparam int NumVals    = 5;
  localparam int ValsW      = ValW * NumVals;

  localparam logic [1:0] ACT_INSERT = 2'd0;
  localparam logic [1:0] ACT_LOOKUP = 2'd1;
  localparam logic [1:0] ACT_DELETE = 2'd2;
  localparam logic [1:0] ACT_LIST   = 2'd3;

  localparam logic [2:0] ST_ADDED   = 3'd0;
  localparam logic [2:0] ST_DUP     = 3'd1;
  localparam logic [2:0] ST_FULL    = 3'd2;
  localparam logic [2:0] ST_FOUND   = 3'd3;
  localparam logic [2:0] ST_MISSING = 3'd4;
  localparam logic [2:0] ST_DELETED = 3'd5;
  localparam logic [2:0] ST_ENTRY   = 3'd6;
  localparam logic [2:0] ST_EMPTY   = 3'd7;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic clr_en;
  } store_cmd_t;

endpackage

@@ hdl/keyed_record_table_top.sv @@
// lookup, delete and insert stop at the first slot holding the key, else walk every slot;
// a list ends after MaxResults entries or at the last slot
// one request at a time, the next one is taken once the walk has handed its result to the output;
// each slot takes a read state and a compare state, output stalls stretch the walk
// reset clears all valid bits at once, no clearing pass; key and value memories are not reset
module keyed_record_table_top #(
  parameter int SLOTS = krt_pkg::SlotsDef
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         action_i,
  input  logic signed [31:0] roll_key_i,
  input  logic signed [7:0]  mark_one_i,
  input  logic signed [7:0]  mark_two_i,
  input  logic signed [7:0]  mark_three_i,
  input  logic signed [7:0]  mark_four_i,
  input  logic signed [7:0]  mark_five_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [2:0]         status_o,
  output logic signed [31:0] key_out_o,
  output logic signed [7:0]  value_one_o,
  output logic signed [7:0]  value_two_o,
  output logic signed [7:0]  value_three_o,
  output logic signed [7:0]  value_four_o,
  output logic signed [7:0]  value_five_o,
  output logic               last_of_run_o
);

  localparam int IdxW = (SLOTS > 1) ? $clog2(SLOTS) : 1;

  krt_pkg::store_cmd_t        cmd;
  logic [IdxW-1:0]            rd_addr;
  logic [IdxW-1:0]            wr_addr;
  logic [krt_pkg::KeyW-1:0]   wr_key;
  logic [krt_pkg::ValsW-1:0]  wr_vals;
  logic [krt_pkg::KeyW-1:0]   rd_key;
  logic [krt_pkg::ValsW-1:0]  rd_vals;
  logic                       rd_valid;
  logic [krt_pkg::ValsW-1:0]  in_vals;
  logic [krt_pkg::ValsW-1:0]  out_vals;
  logic [krt_pkg::KeyW-1:0]   out_key;

  // first value in the low byte
  assign in_vals = {mark_five_i, mark_four_i, mark_three_i, mark_two_i, mark_one_i};

  krt_seq #(
    .SLOTS(SLOTS)
  ) u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .action_i    (action_i),
    .key_i       (roll_key_i),
    .vals_i      (in_vals),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .status_o    (status_o),
    .key_o       (out_key),
    .vals_o      (out_vals),
    .last_o      (last_of_run_o),
    .cmd_o       (cmd),
    .rd_addr_o   (rd_addr),
    .wr_addr_o   (wr_addr),
    .wr_key_o    (wr_key),
    .wr_vals_o   (wr_vals),
    .rd_key_i    (rd_key),
    .rd_vals_i   (rd_vals),
    .rd_valid_i  (rd_valid)
  );

  krt_store #(
    .SLOTS(SLOTS)
  ) u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (cmd),
    .rd_addr_i  (rd_addr),
    .wr_addr_i  (wr_addr),
    .wr_key_i   (wr_key),
    .wr_vals_i  (wr_vals),
    .rd_key_o   (rd_key),
    .rd_vals_o  (rd_vals),
    .rd_valid_o (rd_valid)
  );

  assign key_out_o     = out_key;
  assign value_one_o   = out_vals[7:0];
  assign value_two_o   = out_vals[15:8];
  assign value_three_o = out_vals[23:16];
  assign value_four_o  = out_vals[31:24];
  assign value_five_o  = out_vals[39:32];

endmodule

@@ hdl/krt_store.sv @@
module krt_store #(
  parameter int  SLOTS = krt_pkg::SlotsDef,
  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  krt_pkg::store_cmd_t        cmd_i,
  input  logic [IdxW-1:0]            rd_addr_i,
  input  logic [IdxW-1:0]            wr_addr_i,
  input  logic [krt_pkg::KeyW-1:0]   wr_key_i,
  input  logic [krt_pkg::ValsW-1:0]  wr_vals_i,
  output logic [krt_pkg::KeyW-1:0]   rd_key_o,
  output logic [krt_pkg::ValsW-1:0]  rd_vals_o,
  output logic                       rd_valid_o
);

  logic [krt_pkg::KeyW-1:0]  key_mem [SLOTS];
  logic [krt_pkg::ValsW-1:0] val_mem [SLOTS];
  logic [SLOTS-1:0]          valid_q;
  logic [krt_pkg::KeyW-1:0]  rd_key_q;
  logic [krt_pkg::ValsW-1:0] rd_vals_q;
  logic                      rd_valid_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.wr_en) begin
      key_mem[wr_addr_i] <= wr_key_i;
      val_mem[wr_addr_i] <= wr_vals_i;
    end
    if (cmd_i.rd_en) begin
      rd_key_q  <= key_mem[rd_addr_i];
      rd_vals_q <= val_mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q    <= '0;
      rd_valid_q <= 1'b0;
    end else begin
      if (cmd_i.wr_en) valid_q[wr_addr_i] <= 1'b1;
      if (cmd_i.clr_en) valid_q[wr_addr_i] <= 1'b0;
      if (cmd_i.rd_en) rd_valid_q <= valid_q[rd_addr_i];
    end
  end

  assign rd_key_o   = rd_key_q;
  assign rd_vals_o  = rd_vals_q;
  assign rd_valid_o = rd_valid_q;

endmodule

@@ hdl/krt_seq.sv @@
module krt_seq #(
  parameter int  SLOTS = krt_pkg::SlotsDef,
  localparam int IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  logic [1:0]                 action_i,
  input  logic [krt_pkg::KeyW-1:0]   key_i,
  input  logic [krt_pkg::ValsW-1:0]  vals_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output logic [2:0]                 status_o,
  output logic [krt_pkg::KeyW-1:0]   key_o,
  output logic [krt_pkg::ValsW-1:0]  vals_o,
  output logic                       last_o,
  output krt_pkg::store_cmd_t        cmd_o,
  output logic [IdxW-1:0]            rd_addr_o,
  output logic [IdxW-1:0]            wr_addr_o,
  output logic [krt_pkg::KeyW-1:0]   wr_key_o,
  output logic [krt_pkg::ValsW-1:0]  wr_vals_o,
  input  logic [krt_pkg::KeyW-1:0]   rd_key_i,
  input  logic [krt_pkg::ValsW-1:0]  rd_vals_i,
  input  logic                       rd_valid_i
);

  localparam int CntW = $clog2(krt_pkg::MaxResults + 1);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_RD   = 4'b0010,
    S_CHK  = 4'b0100,
    S_FIN  = 4'b1000
  } state_e;

  state_e                    state_q, state_d;
  logic [1:0]                act_q, act_d;
  logic [krt_pkg::KeyW-1:0]  key_q, key_d;
  logic [krt_pkg::ValsW-1:0] in_vals_q, in_vals_d;
  logic [IdxW-1:0]           idx_q, idx_d;
  logic [IdxW-1:0]           free_idx_q, free_idx_d;
  logic                      free_found_q, free_found_d;
  logic                      pending_q, pending_d;
  logic [CntW-1:0]           cnt_q, cnt_d;
  logic [2:0]                res_status_q, res_status_d;
  logic [krt_pkg::KeyW-1:0]  res_key_q, res_key_d;
  logic [krt_pkg::ValsW-1:0] res_vals_q, res_vals_d;

  logic                      out_valid_q, out_valid_d;
  logic [2:0]                out_status_q, out_status_d;
  logic [krt_pkg::KeyW-1:0]  out_key_q, out_key_d;
  logic [krt_pkg::ValsW-1:0] out_vals_q, out_vals_d;
  logic                      out_last_q, out_last_d;

  logic out_free;
  logic hit;
  logic last_slot;
  logic list_done;

  assign out_free  = !out_valid_q || !out_stall_i;
  assign hit       = rd_valid_i && (rd_key_i == key_q);
  assign last_slot = (idx_q == IdxW'(SLOTS - 1));
  assign list_done = (rd_valid_i && (cnt_q == CntW'(krt_pkg::MaxResults - 1))) || last_slot;

  always_comb begin
    state_d      = state_q;
    act_d        = act_q;
    key_d        = key_q;
    in_vals_d    = in_vals_q;
    idx_d        = idx_q;
    free_idx_d   = free_idx_q;
    free_found_d = free_found_q;
    pending_d    = pending_q;
    cnt_d        = cnt_q;
    res_status_d = res_status_q;
    res_key_d    = res_key_q;
    res_vals_d   = res_vals_q;
    out_valid_d  = out_valid_q && out_stall_i;
    out_status_d = out_status_q;
    out_key_d    = out_key_q;
    out_vals_d   = out_vals_q;
    out_last_d   = out_last_q;
    cmd_o        = '0;
    wr_addr_o    = idx_q;

    case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          act_d        = action_i;
          key_d        = key_i;
          in_vals_d    = vals_i;
          idx_d        = '0;
          free_found_d = 1'b0;
          pending_d    = 1'b0;
          cnt_d        = '0;
          res_key_d    = '0;
          res_vals_d   = '0;
          state_d      = S_RD;
        end
      end
      S_RD: begin
        cmd_o.rd_en = 1'b1;
        state_d     = S_CHK;
      end
      S_CHK: begin
        case (act_q)
          krt_pkg::ACT_INSERT: begin
            if (hit) begin
              res_status_d = krt_pkg::ST_DUP;
              state_d      = S_FIN;
            end else begin
              if (!rd_valid_i && !free_found_q) begin
                free_found_d = 1'b1;
                free_idx_d   = idx_q;
              end
              if (last_slot) begin
                state_d = S_FIN;
                if (free_found_q || !rd_valid_i) begin
                  cmd_o.wr_en  = 1'b1;
                  wr_addr_o    = free_found_q ? free_idx_q : idx_q;
                  res_status_d = krt_pkg::ST_ADDED;
                end else begin
                  res_status_d = krt_pkg::ST_FULL;
                end
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = S_RD;
              end
            end
          end
          krt_pkg::ACT_LOOKUP: begin
            if (hit) begin
              res_status_d = krt_pkg::ST_FOUND;
              res_key_d    = rd_key_i;
              res_vals_d   = rd_vals_i;
              state_d      = S_FIN;
            end else if (last_slot) begin
              res_status_d = krt_pkg::ST_MISSING;
              state_d      = S_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
          krt_pkg::ACT_DELETE: begin
            if (hit) begin
              cmd_o.clr_en = 1'b1;
              res_status_d = krt_pkg::ST_DELETED;
              state_d      = S_FIN;
            end else if (last_slot) begin
              res_status_d = krt_pkg::ST_MISSING;
              state_d      = S_FIN;
            end else begin
              idx_d   = idx_q + 1'b1;
              state_d = S_RD;
            end
          end
          default: begin
            // an earlier entry is held back until we know whether it is the last one
            if (!(rd_valid_i && pending_q && !out_free)) begin
              if (rd_valid_i) begin
                if (pending_q) begin
                  out_valid_d  = 1'b1;
                  out_status_d = krt_pkg::ST_ENTRY;
                  out_key_d    = res_key_q;
                  out_vals_d   = '0;
                  out_last_d   = 1'b0;
                end
                res_key_d = rd_key_i;
                pending_d = 1'b1;
                cnt_d     = cnt_q + 1'b1;
              end
              if (list_done) begin
                state_d      = S_FIN;
                res_status_d = (rd_valid_i || pending_q) ? krt_pkg::ST_ENTRY
                                                         : krt_pkg::ST_EMPTY;
              end else begin
                idx_d   = idx_q + 1'b1;
                state_d = S_RD;
              end
            end
          end
        endcase
      end
      S_FIN: begin
        if (out_free) begin
          out_valid_d  = 1'b1;
          out_status_d = res_status_q;
          out_key_d    = res_key_q;
          out_vals_d   = res_vals_q;
          out_last_d   = 1'b1;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      free_found_q <= 1'b0;
      pending_q    <= 1'b0;
      cnt_q        <= '0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q      <= state_d;
      free_found_q <= free_found_d;
      pending_q    <= pending_d;
      cnt_q        <= cnt_d;
      out_valid_q  <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    act_q        <= act_d;
    key_q        <= key_d;
    in_vals_q    <= in_vals_d;
    idx_q        <= idx_d;
    free_idx_q   <= free_idx_d;
    res_status_q <= res_status_d;
    res_key_q    <= res_key_d;
    res_vals_q   <= res_vals_d;
    out_status_q <= out_status_d;
    out_key_q    <= out_key_d;
    out_vals_q   <= out_vals_d;
    out_last_q   <= out_last_d;
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign rd_addr_o   = idx_q;
  assign wr_key_o    = key_q;
  assign wr_vals_o   = in_vals_q;
  assign out_valid_o = out_valid_q;
  assign status_o    = out_status_q;
  assign key_o       = out_key_q;
  assign vals_o      = out_vals_q;
  assign last_o      = out_last_q;

  a_wr_only_insert: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.wr_en |-> (state_q == S_CHK) && (act_q == krt_pkg::ACT_INSERT) && !hit)
    else $error("table write outside an insert walk");

  a_clr_only_hit: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.clr_en |-> (act_q == krt_pkg::ACT_DELETE) && rd_valid_i)
    else $error("valid bit cleared without a matching entry");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CntW'(krt_pkg::MaxResults))
    else $error("list count past its limit");

  a_start_walk: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && !in_stall_o) |=> (state_q == S_RD))
    else $error("accepted request did not start a walk");

endmodule

@@ sim/keyed_record_table_top_tb.sv @@
module keyed_record_table_top_tb;

  localparam int CycleLimit  = 1_000_000;
  localparam int RandomItems = 420;
  localparam int PoolSize    = 12;

  typedef logic signed [krt_pkg::KeyW-1:0] rec_key_t;
  typedef logic [krt_pkg::NumVals-1:0][krt_pkg::ValW-1:0] mark_set_t;

  typedef struct {
    logic [2:0] status;
    rec_key_t   key;
    mark_set_t  vals;
    logic       last;
  } table_reply_t;

  // mirror of the record table, one expected response per queue entry
  class record_table_scoreboard;
    rec_key_t     slot_key  [krt_pkg::SlotsDef];
    mark_set_t    slot_vals [krt_pkg::SlotsDef];
    bit           slot_used [krt_pkg::SlotsDef];
    table_reply_t pending_replies [$];
    int           errors;

    function new();
      foreach (slot_used[i]) begin
        slot_used[i] = 1'b0;
        slot_key[i]  = '0;
        slot_vals[i] = '0;
      end
      errors = 0;
    endfunction

    function int find_slot(rec_key_t key);
      for (int i = 0; i < krt_pkg::SlotsDef; i++)
        if (slot_used[i] && slot_key[i] == key) return i;
      return -1;
    endfunction

    function void push_reply(logic [2:0] status, rec_key_t key, mark_set_t vals, logic last);
      table_reply_t r;
      r.status = status;
      r.key    = key;
      r.vals   = vals;
      r.last   = last;
      pending_replies.push_back(r);
    endfunction

    function void note_request(logic [1:0] act, rec_key_t key, mark_set_t marks);
      int hit;
      int free_slot;
      int listed;
      table_reply_t tail;
      hit = find_slot(key);
      case (act)
        krt_pkg::ACT_INSERT: begin
          free_slot = -1;
          for (int i = krt_pkg::SlotsDef - 1; i >= 0; i--)
            if (!slot_used[i]) free_slot = i;
          if (hit >= 0) begin
            push_reply(krt_pkg::ST_DUP, '0, '0, 1'b1);
          end else if (free_slot < 0) begin
            push_reply(krt_pkg::ST_FULL, '0, '0, 1'b1);
          end else begin
            slot_key[free_slot]  = key;
            slot_vals[free_slot] = marks;
            slot_used[free_slot] = 1'b1;
            push_reply(krt_pkg::ST_ADDED, '0, '0, 1'b1);
          end
        end
        krt_pkg::ACT_LOOKUP: begin
          if (hit < 0) push_reply(krt_pkg::ST_MISSING, '0, '0, 1'b1);
          else push_reply(krt_pkg::ST_FOUND, slot_key[hit], slot_vals[hit], 1'b1);
        end
        krt_pkg::ACT_DELETE: begin
          if (hit < 0) begin
            push_reply(krt_pkg::ST_MISSING, '0, '0, 1'b1);
          end else begin
            slot_used[hit] = 1'b0;
            push_reply(krt_pkg::ST_DELETED, '0, '0, 1'b1);
          end
        end
        default: begin
          listed = 0;
          for (int i = 0; i < krt_pkg::SlotsDef && listed < krt_pkg::MaxResults; i++) begin
            if (slot_used[i]) begin
              push_reply(krt_pkg::ST_ENTRY, slot_key[i], '0, 1'b0);
              listed++;
            end
          end
          if (listed == 0) begin
            push_reply(krt_pkg::ST_EMPTY, '0, '0, 1'b1);
          end else begin
            tail = pending_replies.pop_back();
            tail.last = 1'b1;
            pending_replies.push_back(tail);
          end
        end
      endcase
    endfunction

    function void check_result(table_reply_t got);
      table_reply_t want;
      string val_names [krt_pkg::NumVals] = '{"value_one", "value_two", "value_three",
                                              "value_four", "value_five"};
      if (pending_replies.size() == 0) begin
        $error("unexpected response: status %0d key_out %0d", got.status, got.key);
        errors++;
        return;
      end
      want = pending_replies.pop_front();
      if (got.status !== want.status) begin
        $error("status: expected %0d, actual %0d", want.status, got.status);
        errors++;
      end
      if (got.key !== want.key) begin
        $error("key_out: expected %0d, actual %0d", want.key, got.key);
        errors++;
      end
      for (int j = 0; j < krt_pkg::NumVals; j++) begin
        if (got.vals[j] !== want.vals[j]) begin
          $error("%s: expected %0d, actual %0d", val_names[j],
                 $signed(want.vals[j]), $signed(got.vals[j]));
          errors++;
        end
      end
      if (got.last !== want.last) begin
        $error("last_of_run: expected %0b, actual %0b", want.last, got.last);
        errors++;
      end
    endfunction
  endclass

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic              in_valid   = 1'b0;
  logic [1:0]        action     = krt_pkg::ACT_INSERT;
  rec_key_t          roll_key   = '0;
  logic signed [7:0] mark_one   = '0;
  logic signed [7:0] mark_two   = '0;
  logic signed [7:0] mark_three = '0;
  logic signed [7:0] mark_four  = '0;
  logic signed [7:0] mark_five  = '0;
  logic              out_stall  = 1'b0;

  logic              in_stall;
  logic              out_valid;
  logic [2:0]        status;
  rec_key_t          key_out;
  logic signed [7:0] value_one;
  logic signed [7:0] value_two;
  logic signed [7:0] value_three;
  logic signed [7:0] value_four;
  logic signed [7:0] value_five;
  logic              last_of_run;

  record_table_scoreboard sb;
  table_reply_t seen_reply;
  bit sender_calm = 1'b0;
  int unsigned cycle_count = 0;

  keyed_record_table_top u_top (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid),
    .in_stall_o    (in_stall),
    .action_i      (action),
    .roll_key_i    (roll_key),
    .mark_one_i    (mark_one),
    .mark_two_i    (mark_two),
    .mark_three_i  (mark_three),
    .mark_four_i   (mark_four),
    .mark_five_i   (mark_five),
    .out_valid_o   (out_valid),
    .out_stall_i   (out_stall),
    .status_o      (status),
    .key_out_o     (key_out),
    .value_one_o   (value_one),
    .value_two_o   (value_two),
    .value_three_o (value_three),
    .value_four_o  (value_four),
    .value_five_o  (value_five),
    .last_of_run_o (last_of_run)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CycleLimit) begin
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // mostly back to back, some short gaps, a few long ones
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  function automatic mark_set_t random_marks();
    mark_set_t m;
    for (int j = 0; j < krt_pkg::NumVals; j++) begin
      case ($urandom_range(0, 9))
        0: m[j] = 8'h80;
        1: m[j] = 8'h7f;
        default: m[j] = 8'($urandom_range(0, 255));
      endcase
    end
    return m;
  endfunction

  function automatic logic [1:0] pick_action(bit filling);
    int r;
    r = $urandom_range(0, 99);
    if (filling) begin
      if (r < 50) return krt_pkg::ACT_INSERT;
      if (r < 70) return krt_pkg::ACT_LOOKUP;
      if (r < 85) return krt_pkg::ACT_DELETE;
      return krt_pkg::ACT_LIST;
    end
    if (r < 15) return krt_pkg::ACT_INSERT;
    if (r < 35) return krt_pkg::ACT_LOOKUP;
    if (r < 85) return krt_pkg::ACT_DELETE;
    return krt_pkg::ACT_LIST;
  endfunction

  // valid stays high across back-to-back requests, only the payload moves
  task automatic send_request(input logic [1:0] act, input rec_key_t key,
                              input mark_set_t marks);
    int gap;
    gap = sender_calm ? 0 : pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid   <= 1'b1;
    action     <= act;
    roll_key   <= key;
    mark_one   <= marks[0];
    mark_two   <= marks[1];
    mark_three <= marks[2];
    mark_four  <= marks[3];
    mark_five  <= marks[4];
    @(posedge clk_i);
    while (in_stall !== 1'b0) @(posedge clk_i);
    sb.note_request(act, key, marks);
  endtask

  always @(posedge clk_i) begin
    if (rst_ni && out_valid === 1'b1 && !out_stall) begin
      seen_reply.status = status;
      seen_reply.key    = key_out;
      seen_reply.vals   = {value_five, value_four, value_three, value_two, value_one};
      seen_reply.last   = last_of_run;
      sb.check_result(seen_reply);
    end
  end

  initial begin
    int hold;
    forever begin
      if ($urandom_range(0, 7) == 0) repeat ($urandom_range(100, 300)) @(posedge clk_i);
      else repeat ($urandom_range(1, 12)) @(posedge clk_i);
      hold = pick_gap();
      if (hold > 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk_i);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    rec_key_t key_pool [PoolSize];
    rec_key_t key;
    bit filling;
    sb = new();
    key_pool[0] = rec_key_t'(32'h8000_0000);
    key_pool[1] = rec_key_t'(32'h7fff_ffff);
    key_pool[2] = '0;
    key_pool[3] = '1;
    for (int i = 4; i < PoolSize; i++) key_pool[i] = rec_key_t'($urandom);

    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // empty table: list, misses on lookup and delete
    send_request(krt_pkg::ACT_LIST, '0, '0);
    send_request(krt_pkg::ACT_LOOKUP, '0, '0);
    send_request(krt_pkg::ACT_DELETE, '0, '0);
    // fill with extreme keys and values, one duplicate on the way
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(32'h8000_0000),
                 {8'h01, 8'hff, 8'h00, 8'h7f, 8'h80});
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(32'h7fff_ffff),
                 {8'h55, 8'h00, 8'hff, 8'h80, 8'h7f});
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(32'h8000_0000), random_marks());
    send_request(krt_pkg::ACT_INSERT, '0, {8'haa, 8'h80, 8'h7f, 8'h01, 8'hff});
    send_request(krt_pkg::ACT_INSERT, '1, random_marks());
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(32'h5555_5555), random_marks());
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(32'haaaa_aaaa), random_marks());
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(1), random_marks());
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(32'h1234_5678), random_marks());
    // table full now
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(42), random_marks());
    send_request(krt_pkg::ACT_LIST, '0, '0);
    send_request(krt_pkg::ACT_LOOKUP, rec_key_t'(32'h7fff_ffff), '0);
    send_request(krt_pkg::ACT_LOOKUP, rec_key_t'(32'h8000_0000), '0);
    send_request(krt_pkg::ACT_LOOKUP, rec_key_t'(32'h1234_5678), '0);
    send_request(krt_pkg::ACT_DELETE, '0, '0);
    send_request(krt_pkg::ACT_LOOKUP, '0, '0);
    send_request(krt_pkg::ACT_DELETE, '0, '0);
    // freed middle slot is reused first
    send_request(krt_pkg::ACT_INSERT, rec_key_t'(42), random_marks());
    send_request(krt_pkg::ACT_LIST, '0, '0);
    send_request(krt_pkg::ACT_LOOKUP, rec_key_t'(42), '0);
    send_request(krt_pkg::ACT_DELETE, rec_key_t'(32'h1234_5678), '0);

    filling = 1'b0;
    for (int n = 0; n < RandomItems; n++) begin
      if (n % 50 == 0) begin
        filling = ~filling;
        sender_calm = ($urandom_range(0, 3) == 0);
      end
      if ($urandom_range(0, 99) < 85) key = key_pool[$urandom_range(0, PoolSize - 1)];
      else key = rec_key_t'($urandom);
      send_request(pick_action(filling), key, random_marks());
    end
    in_valid <= 1'b0;

    while (sb.pending_replies.size() != 0) @(posedge clk_i);
    repeat (2 * krt_pkg::SlotsDef + 16) @(posedge clk_i);
    if (sb.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
